[hw/rtl/zst_pkg.sv]
// Shared types, constants and the pixel decision function for the
// Zhang-Suen thinning sub-pass block.
// Used by zhang_suen_thinning_pass and its port checker.
package zst_pkg;

    // Default size bounds of the frame
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE        = 2'd2;

    // Register reset values
    localparam int RST_FRAME_WIDTH  = 640;
    localparam int RST_FRAME_HEIGHT = 480;

    // Foreground neighbor count bounds for removal
    localparam logic [3:0] FG_MIN = 4'd2;
    localparam logic [3:0] FG_MAX = 4'd6;

    // Phase codes
    localparam logic PHASE_SE = 1'b0;

    // Input item
    typedef struct packed {
        logic [7:0] in_pixel;
        logic       drain;
    } pixel_item_t;

    // Result item
    typedef struct packed {
        logic [7:0] out_pixel;
        logic       out_last;
    } result_item_t;

    // Per-item control carried from the input register to the result stage
    typedef struct packed {
        logic col_zero;   // item starts a row
        logic produce;    // item yields a result
        logic last;       // result is the last pixel of the frame
        logic upper_ok;   // upper line value is inside the frame
        logic middle_ok;  // middle line value is inside the frame
        logic restart;    // frame ends, clear position and window
    } stage_ctl_t;

    // 3x3 window, index row*3+col, entry 4 is the center
    typedef logic [8:0][7:0] window_t;

    // One sub-pass decision: returns the center kept or 0 when removed
    function automatic logic [7:0] zs_decide(window_t w, logic ph);
        logic [7:0] p;
        logic [3:0] fg;
        logic [3:0] rises;
        logic       keep;
        logic [7:0] res;
        int         k;
        // ring N, NE, E, SE, S, SW, W, NW
        p[0] = |w[1];
        p[1] = |w[2];
        p[2] = |w[5];
        p[3] = |w[8];
        p[4] = |w[7];
        p[5] = |w[6];
        p[6] = |w[3];
        p[7] = |w[0];
        fg    = '0;
        rises = '0;
        for (k = 0; k < 8; k++)
        begin
            fg    = fg + 4'(p[k]);
            rises = rises + 4'(p[k] && !p[3'(k + 7)]);
        end
        if (ph == PHASE_SE)
            keep = p[2] && p[4] && (p[0] || p[6]);
        else
            keep = p[0] && p[6] && (p[2] || p[4]);
        if (w[4] == 8'd0)
            res = 8'd0;
        else if (fg < FG_MIN || fg > FG_MAX || rises != 4'd1)
            res = w[4];
        else
            res = keep ? w[4] : 8'd0;
        return res;
    endfunction

endpackage

[hw/rtl/zhang_suen_thinning_pass.sv]
// Top level of the Zhang-Suen thinning sub-pass block: position counters,
// line memory, 3x3 window and result register. Depends on zst_pkg.
//
// The block takes one pixel item per clock and gives one result item per
// clock once the window is primed, unless result stall holds the pipeline:
// a pixel's result comes out frame_width+1 items after it went in, so each
// frame needs frame_width+1 drain (or any) items after its last pixel to
// push the tail out; the item that pushes out the last pixel (out_last
// high) also clears the position and window for the next frame. Inside the
// block an item waits in the input register, where the line memory is read,
// and then lands in the result register. The rate of one item per clock is
// set by the line memory, which is read once and written once each cycle.
// Pixels outside the frame are taken as background. Writing frame_width or
// frame_height restarts the frame; configuration is to be written only while
// the block is idle, which the block itself does not enforce. pixel_stall
// rises only while a result waits and another item is already in flight.
module zhang_suen_thinning_pass
    import zst_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // pixel channel
    input  logic                   pixel_valid,
    output logic                   pixel_stall,
    input  pixel_item_t            pixel,
    // result channel
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_item_t           result,
    // configuration write port
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);       // column / line memory address
    localparam int WW = $clog2(MAX_WIDTH + 1);   // effective width
    localparam int HW = $clog2(MAX_HEIGHT + 1);  // effective height
    localparam int RW = $clog2(MAX_HEIGHT + 2);  // row counter, up to height+1
    localparam int RST_W = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
    localparam int RST_H = (RST_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_FRAME_HEIGHT;

    // configuration
    logic [WW-1:0] eff_w_reg, eff_w_next;
    logic [HW-1:0] eff_h_reg, eff_h_next;
    logic          phase_reg, phase_next;
    logic          cfg_restart;

    // position of the next incoming item
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // input register
    logic          s1_valid_reg, s1_valid_next;
    stage_ctl_t    s1_ctl_reg, s1_ctl_next;
    logic [7:0]    s1_x_reg;
    logic [CW-1:0] s1_addr_reg;

    // line memory: upper line in [15:8], middle line in [7:0]
    logic [15:0]   line_mem [MAX_WIDTH];
    logic [15:0]   rd_word_reg;
    logic [15:0]   fwd_word_reg;
    logic          fwd_hit_reg;
    logic [15:0]   rd_word;
    logic [15:0]   wr_word;

    // window and result register
    window_t       win_reg, win_next;
    window_t       dec_win;
    logic          out_valid_reg, out_valid_next;
    result_item_t  out_data_reg;

    logic          accept;
    logic          adv;
    logic          fire;
    logic [RW-1:0] h_ext;
    logic          col_zero;
    logic          col_last;
    logic          row_ge_h;
    logic          row_end;
    logic [7:0]    x_val;
    logic [7:0]    u_val;
    logic [7:0]    m_val;

    // handshake
    assign adv         = !out_valid_reg || !result_stall;
    assign fire        = s1_valid_reg && adv;
    assign pixel_stall = s1_valid_reg && !adv;
    assign accept      = pixel_valid && !pixel_stall;

    // configuration writes, sizes saturated to the supported range
    always_comb
    begin
        eff_w_next  = eff_w_reg;
        eff_h_next  = eff_h_reg;
        phase_next  = phase_reg;
        cfg_restart = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    cfg_restart = 1'b1;
                    if (cfg_data[10:0] == 11'd0)
                        eff_w_next = WW'(1);
                    else if (32'(cfg_data[10:0]) > MAX_WIDTH)
                        eff_w_next = WW'(MAX_WIDTH);
                    else
                        eff_w_next = WW'(cfg_data[10:0]);
                end
                REG_FRAME_HEIGHT:
                begin
                    cfg_restart = 1'b1;
                    if (cfg_data == '0)
                        eff_h_next = HW'(1);
                    else if (32'(cfg_data) > MAX_HEIGHT)
                        eff_h_next = HW'(MAX_HEIGHT);
                    else
                        eff_h_next = HW'(cfg_data);
                end
                REG_PHASE:
                begin
                    phase_next = cfg_data[0];
                end
                default:
                begin
                    cfg_restart = 1'b0;
                end
            endcase
        end
    end

    // position decode of the incoming item
    assign h_ext    = RW'(eff_h_reg);
    assign col_zero = (col_reg == '0);
    assign col_last = (WW'(col_reg) == eff_w_reg - WW'(1));
    assign row_ge_h = (row_reg >= h_ext);
    assign row_end  = (row_reg == h_ext + RW'(1));
    assign x_val    = (pixel.drain || row_ge_h) ? 8'd0 : pixel.in_pixel;

    always_comb
    begin
        s1_ctl_next.col_zero  = col_zero;
        s1_ctl_next.produce   = col_zero ? (row_reg >= RW'(2)) : (row_reg >= RW'(1));
        s1_ctl_next.last      = col_zero && row_end;
        s1_ctl_next.upper_ok  = (row_reg >= RW'(2));
        s1_ctl_next.middle_ok = (row_reg >= RW'(1)) && (row_reg <= h_ext);
        s1_ctl_next.restart   = col_zero && row_end;
    end

    // position counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_zero && row_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_last)
            begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // input register occupancy
    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg     <= WW'(RST_W);
            eff_h_reg     <= HW'(RST_H);
            phase_reg     <= PHASE_SE;
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s1_ctl_reg    <= '0;
            fwd_hit_reg   <= 1'b0;
            win_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            eff_w_reg     <= eff_w_next;
            eff_h_reg     <= eff_h_next;
            phase_reg     <= phase_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            win_reg       <= win_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                s1_ctl_reg  <= s1_ctl_next;
                fwd_hit_reg <= fire && (s1_addr_reg == col_reg);
            end
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg     <= x_val;
            s1_addr_reg  <= col_reg;
            fwd_word_reg <= wr_word;
        end
    end

    // line memory: read at accept, write back when the item moves on
    always_ff @(posedge clk)
    begin
        if (fire)
            line_mem[s1_addr_reg] <= wr_word;
        if (accept)
            rd_word_reg <= line_mem[col_reg];
    end

    // a write to the same column in the read cycle bypasses the memory
    assign rd_word = fwd_hit_reg ? fwd_word_reg : rd_word_reg;
    assign u_val   = s1_ctl_reg.upper_ok ? rd_word[15:8] : 8'd0;
    assign m_val   = s1_ctl_reg.middle_ok ? rd_word[7:0] : 8'd0;
    assign wr_word = {m_val, s1_x_reg};

    // window shifted by one column; a row start closes the previous row
    always_comb
    begin
        dec_win    = win_reg;
        dec_win[0] = win_reg[1];
        dec_win[1] = win_reg[2];
        dec_win[3] = win_reg[4];
        dec_win[4] = win_reg[5];
        dec_win[6] = win_reg[7];
        dec_win[7] = win_reg[8];
        dec_win[2] = s1_ctl_reg.col_zero ? 8'd0 : u_val;
        dec_win[5] = s1_ctl_reg.col_zero ? 8'd0 : m_val;
        dec_win[8] = s1_ctl_reg.col_zero ? 8'd0 : s1_x_reg;
    end

    // window update
    always_comb
    begin
        win_next = win_reg;
        if (cfg_restart)
        begin
            win_next = '0;
        end
        else if (fire)
        begin
            if (s1_ctl_reg.restart)
            begin
                win_next = '0;
            end
            else if (s1_ctl_reg.col_zero)
            begin
                win_next    = '0;
                win_next[2] = u_val;
                win_next[5] = m_val;
                win_next[8] = s1_x_reg;
            end
            else
            begin
                win_next = dec_win;
            end
        end
    end

    // result register
    always_comb
    begin
        if (fire)
            out_valid_next = s1_ctl_reg.produce;
        else if (!result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg.out_pixel <= zs_decide(dec_win, phase_reg);
            out_data_reg.out_last  <= s1_ctl_reg.last;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

[hw/rtl/zst_port_checker.sv]
// Port-level checker for zhang_suen_thinning_pass and its bind statement.
// Depends on zst_pkg.
module zst_port_checker
    import zst_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         pixel_valid,
    input logic         pixel_stall,
    input logic         result_valid,
    input logic         result_stall,
    input result_item_t result
);

    // a waiting result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result item dropped while stalled");

    // a waiting result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result item changed while stalled");

    // a new result only follows an accepted pixel item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(pixel_valid && !pixel_stall, 2))
        else $error("result item without a matching accepted item");

    // the pixel side only stalls behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> result_valid && result_stall)
        else $error("pixel stall without a blocked result");

endmodule

bind zhang_suen_thinning_pass zst_port_checker u_zst_port_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

[tb/zst_stream_checker.sv]
// Stream checker for the Zhang-Suen thinning sub-pass: watches the pixel, result
// and configuration ports, predicts each result item and compares it.
// Depends on zst_pkg for the item types, register indexes and size bounds.
module zst_stream_checker
    import zst_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pixel_valid,
    input  logic                   pixel_stall,
    input  pixel_item_t            pixel,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  result_item_t           result,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     errors,
    output int                     outstanding,
    output int                     checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // keep the log short when the block is badly broken
    localparam int REPORT_CAP = 100;

    // shadow registers
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic        phase_reg;

    // shadow line memory, window and position
    logic [7:0]  upper_row [DEF_MAX_WIDTH];
    logic [7:0]  middle_row [DEF_MAX_WIDTH];
    window_t     win;
    int          col_pos;
    int          row_pos;

    // predicted result items, oldest first
    result_item_t thinned_q [$];

    int mismatches = 0;
    int compared   = 0;
    int pending_n  = 0;

    assign errors      = mismatches;
    assign outstanding = pending_n;
    assign checked     = compared;

    // register value to size in use: 0 means 1, large values saturate
    function automatic int clamp_dim(input int raw, input int hi);
        if (raw < 1)
            return 1;
        if (raw > hi)
            return hi;
        return raw;
    endfunction

    // one sub-pass decision on the center of the window
    function automatic logic [7:0] thin_center(input window_t nb, input logic ph);
        logic [7:0] ring;
        int         fg;
        int         rises;
        logic       blocked;
        // ring bit 0 is N, then NE, E, SE, S, SW, W, NW
        ring = {|nb[0], |nb[3], |nb[6], |nb[7], |nb[8], |nb[5], |nb[2], |nb[1]};
        fg    = 0;
        rises = 0;
        for (int k = 0; k < 8; k++)
        begin
            if (ring[k])
            begin
                fg++;
                if (!ring[(k + 7) % 8])
                    rises++;
            end
        end
        if (nb[4] == 8'd0)
            return 8'd0;
        if (fg < 2 || fg > 6 || rises != 1)
            return nb[4];
        if (ph == PHASE_SE)
            blocked = ring[2] && ring[4] && (ring[0] || ring[6]);
        else
            blocked = ring[0] && ring[6] && (ring[2] || ring[4]);
        return blocked ? nb[4] : 8'd0;
    endfunction

    task automatic restart_frame();
        win     = '0;
        col_pos = 0;
        row_pos = 0;
    endtask

    // take one accepted pixel item, queue the result it completes
    task automatic shift_pixel(input pixel_item_t it);
        int           w;
        int           h;
        int           r;
        int           c;
        logic [7:0]   x;
        logic [7:0]   u;
        logic [7:0]   m;
        result_item_t done;
        w = clamp_dim(width_reg, DEF_MAX_WIDTH);
        h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
        r = row_pos;
        c = col_pos;
        if (c >= w)
            c = 0;
        // drains and flush rows read as background
        x = (it.drain || r >= h) ? 8'd0 : it.in_pixel;
        u = (r >= 2 && r - 2 < h) ? upper_row[c] : 8'd0;
        m = (r >= 1 && r - 1 < h) ? middle_row[c] : 8'd0;
        upper_row[c]  = m;
        middle_row[c] = x;
        // slide the window one column left
        for (int k = 0; k < 3; k++)
        begin
            win[k * 3]     = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        if (c == 0)
        begin
            // right edge of the row two back: background column comes in
            win[2] = 8'd0;
            win[5] = 8'd0;
            win[8] = 8'd0;
            if (r >= 2)
            begin
                done.out_pixel = thin_center(win, phase_reg);
                done.out_last  = (r == h + 1);
                thinned_q.push_back(done);
            end
            win    = '0;
            win[2] = u;
            win[5] = m;
            win[8] = x;
        end
        else
        begin
            win[2] = u;
            win[5] = m;
            win[8] = x;
            if (r >= 1)
            begin
                done.out_pixel = thin_center(win, phase_reg);
                done.out_last  = 1'b0;
                thinned_q.push_back(done);
            end
        end
        // advance position; the item that completes the last pixel restarts the frame
        if (c == 0 && r >= h + 1)
            restart_frame();
        else
        begin
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
            end
            col_pos = c;
            row_pos = r;
        end
    endtask

    // follow the ports
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = 11'(RST_FRAME_WIDTH);
            height_reg = 13'(RST_FRAME_HEIGHT);
            phase_reg  = PHASE_SE;
            for (int i = 0; i < DEF_MAX_WIDTH; i++)
            begin
                upper_row[i]  = 8'd0;
                middle_row[i] = 8'd0;
            end
            restart_frame();
            thinned_q.delete();
            pending_n <= 0;
        end
        else
        begin
            // results first: they always belong to items taken earlier
            if (result_valid && !result_stall)
            begin
                if (thinned_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t: unexpected result, expected none, got pixel %0d last %0b",
                                 $time, result.out_pixel, result.out_last);
                end
                else
                begin
                    result_item_t want;
                    want = thinned_q.pop_front();
                    compared++;
                    if (result.out_pixel !== want.out_pixel)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_CAP)
                            $display("%0t: out_pixel mismatch, expected %0d, got %0d",
                                     $time, want.out_pixel, result.out_pixel);
                    end
                    if (result.out_last !== want.out_last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_CAP)
                            $display("%0t: out_last mismatch, expected %0b, got %0b",
                                     $time, want.out_last, result.out_last);
                    end
                end
            end

            if (pixel_valid && !pixel_stall)
                shift_pixel(pixel);

            // register writes
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:
                    begin
                        width_reg = cfg_data[10:0];
                        restart_frame();
                    end
                    REG_FRAME_HEIGHT:
                    begin
                        height_reg = cfg_data[12:0];
                        restart_frame();
                    end
                    REG_PHASE:
                        phase_reg = cfg_data[0];
                    default:
                        ;
                endcase
            end

            pending_n <= thinned_q.size();
        end
    end

endmodule

[tb/testbench.sv]
// Top of the thinning sub-pass testbench: clock, reset, pixel and result
// traffic, register writes and the verdict.
// Depends on zst_pkg, zhang_suen_thinning_pass and zst_stream_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import zst_pkg::*;

    localparam int IDLE_LIMIT  = 2000;  // cycles with no traffic at all
    localparam int HOLD_CYCLES = 150;   // long result hold-off
    localparam int IDLE_PCT    = 8;
    localparam int SETTLE      = 4;     // item in the input register, no result
    localparam int RANDOM_PIXELS = 950;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam logic PHASE_NW = ~PHASE_SE;

    // directed 3x3 frame; the pixel under the drain flag is dropped
    localparam logic [7:0] SHAPE [9] = '{8'd0,   8'd128, 8'd255,
                                         8'd0,   8'd1,   8'd200,
                                         8'd0,   8'd255, 8'd0};
    localparam logic [8:0] SHAPE_DRAIN = 9'b0_1000_0000;

    logic                   clk;
    logic                   rst_n;
    logic                   pixel_valid;
    logic                   pixel_stall;
    pixel_item_t            pixel;
    logic                   result_valid;
    logic                   result_stall;
    result_item_t           result;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int errors;
    int outstanding;
    int checked;
    int live_items  = 0;
    int frames      = 0;
    int idle_cycles = 0;
    bit calm        = 1'b0;

    zhang_suen_thinning_pass u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    zst_stream_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .outstanding  (outstanding),
        .checked      (checked)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog on cycles with no traffic at all
    always @(posedge clk)
    begin
        if (!rst_n || (pixel_valid && !pixel_stall) || (result_valid && !result_stall)
            || cfg_write)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("testbench: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result side: random stalls, one long hold-off while pixels keep coming
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        result_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
                hold_left--;
            else if (!hold_done && live_items > 1000 && pixel_valid)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            result_stall <= (hold_left > 0) || (!calm && $urandom_range(99) < IDLE_PCT);
        end
    end

    function automatic int eff_dim(input int raw, input int hi);
        if (raw < 1)
            return 1;
        if (raw > hi)
            return hi;
        return raw;
    endfunction

    // offer one pixel item, with random gaps, until it is taken
    task automatic push_pixel(input logic [7:0] value, input logic drained);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= pixel_item_t'{in_pixel: value, drain: drained};
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
    endtask

    // stop sending until every predicted result is out and the block is empty
    task automatic wait_idle();
        pixel_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(input int raw_w, input int raw_h, input logic ph);
        write_reg(REG_FRAME_WIDTH, raw_w);
        write_reg(REG_FRAME_HEIGHT, raw_h);
        write_reg(REG_PHASE, ph);
    endtask

    // items first..last-1 of a frame; flush items carry random junk
    task automatic send_frame(input int w, input int h, input int first, input int last,
                              input int density);
        logic [7:0] value;
        logic       drained;
        for (int i = first; i < last; i++)
        begin
            if (i / w < h)
            begin
                value   = ($urandom_range(99) < density) ? 8'($urandom_range(255, 1)) : 8'd0;
                drained = ($urandom_range(99) < 3);
                live_items++;
            end
            else
            begin
                value   = 8'($urandom);
                drained = 1'($urandom);
            end
            push_pixel(value, drained);
        end
    endtask

    task automatic run_frames(input int raw_w, input int raw_h, input logic ph,
                              input int count, input int density);
        int w;
        int h;
        w = eff_dim(raw_w, DEF_MAX_WIDTH);
        h = eff_dim(raw_h, DEF_MAX_HEIGHT);
        set_frame(raw_w, raw_h, ph);
        repeat (count)
        begin
            send_frame(w, h, 0, w * (h + 1) + 1, density);
            frames++;
        end
        wait_idle();
    endtask

    // stimulus
    initial
    begin
        int   raw_w;
        int   raw_h;
        int   w;
        int   h;
        int   len;
        int   cut;
        int   density;
        int   start;
        logic ph;

        rst_n       = 1'b0;
        pixel_valid = 1'b0;
        pixel       = '0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset width and phase, one-row frame cut a little past the row wrap,
        // no idling on either side; the next size write restarts the frame
        calm = 1'b1;
        write_reg(REG_FRAME_HEIGHT, 1);
        send_frame(RST_FRAME_WIDTH, 1, 0, RST_FRAME_WIDTH + 60, 50);
        wait_idle();
        calm = 1'b0;

        // directed 3x3 frame, once per phase; second phase written alone
        set_frame(3, 3, PHASE_SE);
        for (int round = 0; round < 2; round++)
        begin
            if (round == 1)
            begin
                wait_idle();
                write_reg(REG_PHASE, PHASE_NW);
            end
            for (int i = 0; i < 13; i++)
            begin
                if (i < 9)
                    push_pixel(SHAPE[i], SHAPE_DRAIN[i]);
                else
                    push_pixel(8'($urandom), 1'($urandom));
            end
            frames++;
        end
        wait_idle();

        // random small frames, with cut frames and phase flips mid-frame
        start = live_items;
        while (live_items - start < RANDOM_PIXELS)
        begin
            raw_w   = ($urandom_range(11) == 0) ? 0 : $urandom_range(12, 1);
            raw_h   = ($urandom_range(11) == 0) ? 0 : $urandom_range(10, 1);
            w       = eff_dim(raw_w, DEF_MAX_WIDTH);
            h       = eff_dim(raw_h, DEF_MAX_HEIGHT);
            len     = w * (h + 1) + 1;
            ph      = $urandom_range(1) ? PHASE_NW : PHASE_SE;
            density = $urandom_range(85, 20);
            if ($urandom_range(9) == 0)
                write_reg(REG_SPARE, $urandom_range(8191));
            case ($urandom_range(7))
                0:
                begin
                    // cut short; the next size write restarts the frame
                    set_frame(raw_w, raw_h, ph);
                    send_frame(w, h, 0, $urandom_range(len - 1, 1), density);
                    wait_idle();
                end
                1:
                begin
                    // drain halfway, flip the phase, finish the frame
                    cut = len / 2;
                    set_frame(raw_w, raw_h, ph);
                    send_frame(w, h, 0, cut, density);
                    wait_idle();
                    write_reg(REG_PHASE, ph ? PHASE_SE : PHASE_NW);
                    send_frame(w, h, cut, len, density);
                    frames++;
                    wait_idle();
                end
                default:
                    run_frames(raw_w, raw_h, ph, $urandom_range(3, 1), density);
            endcase
        end

        wait_idle();
        repeat (8) @(posedge clk);

        $display("covered %0d frames, %0d in-frame pixels, %0d results checked",
                 frames, live_items, checked);
        $display("a 640-wide row at reset size, frames 1x1 to 12x10, both phases, drains, restarts");
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
